[src/swid_pkg.sv]
// Shared types, register indexes and decode functions for the switch id segment display.
`default_nettype none

package swid_pkg;

   // Command codes of one request word
   localparam logic CMD_REFRESH = 1'b0;
   localparam logic CMD_SAMPLE  = 1'b1;

   // Configuration register indexes
   localparam int  CSR_INDEX_BITS    = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAJOR_VERSION = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MINOR_VERSION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STABLE_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ID_WINDOW     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MARK_WINDOW   = 3'd4;
   localparam int  CSR_DATA_BITS     = 32;

   // Reset values of the configuration registers
   localparam logic [15:0] STABLE_LIMIT_RESET = 16'd1000;
   localparam logic [31:0] ID_WINDOW_RESET    = 32'd300;
   localparam logic [31:0] MARK_WINDOW_RESET  = 32'd400;

   // Digit code that lights nothing (blanked leading zero)
   localparam logic [3:0] DIGIT_BLANK = 4'd10;

   // Digit enable codes
   localparam logic [1:0] ENABLE_NONE = 2'b00;
   localparam logic [1:0] ENABLE_ONES = 2'b01;
   localparam logic [1:0] ENABLE_TENS = 2'b10;

   typedef struct packed {
      logic        command;
      logic [3:0]  switch_bits;
      logic [31:0] system_time;
   } item_type;

   typedef struct packed {
      logic [6:0] segment_bits;
      logic [1:0] digit_enables;
      logic [4:0] device_id;
      logic [6:0] display_number;
   } result_type;

   typedef struct packed {
      logic [3:0]  major_version;
      logic [3:0]  minor_version;
      logic [15:0] stable_limit;
      logic [31:0] id_window;
      logic [31:0] mark_window;
   } cfg_type;

   // Active-low segment pattern, bit0 A to bit6 G
   function automatic logic [6:0] seg_decode(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0:    seg = 7'h40;
         4'd1:    seg = 7'h79;
         4'd2:    seg = 7'h24;
         4'd3:    seg = 7'h30;
         4'd4:    seg = 7'h19;
         4'd5:    seg = 7'h12;
         4'd6:    seg = 7'h02;
         4'd7:    seg = 7'h78;
         4'd8:    seg = 7'h00;
         4'd9:    seg = 7'h10;
         4'd10:   seg = 7'h7F;
         default: seg = 7'h40;
      endcase
      return seg;
   endfunction

   // Tens digit of a value below 100: multiply by 103/1024
   function automatic logic [3:0] tens_of(input logic [6:0] value);
      logic [13:0] prod;
      prod = 14'(value) * 14'd103;
      return prod[13:10];
   endfunction

endpackage

`default_nettype wire

[src/switch_id_two_digit_segment_display.sv]
// Top level of the switch id segment display: request register, handshake and result slot.
//
// Request channel (req_): one word per refresh tick (command 0) or switch sample
// (command 1), accepted when req_valid is high and req_stall is low.
// Result channel (rsp_): one word per request, carrying segment levels, digit
// enables, the accepted device id and the shown number.
// Configuration (csr_): write-only registers, to be written only while the block is
// idle; the block itself does not enforce this. An accepted word waits in the request
// register; the display and debounce state advance, and rsp_valid is set, as it
// moves into the result slot. Throughput: one word per cycle while rsp_stall is low;
// the state update is a single pass between the request register and the state
// registers, which also form the result slot. A stalled result holds; the request
// register still takes one more word; req_stall rises only while it and the slot are full.
// Reset clears both valid flags, the display and debounce state, and loads the
// configuration reset values.
`default_nettype none

module switch_id_two_digit_segment_display #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output wire logic                                req_stall,
   input  wire logic                                req_command,
   input  wire logic [3:0]                          req_switch_bits,
   input  wire logic [31:0]                         req_system_time,
   output wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output wire logic [6:0]                          rsp_segment_bits,
   output wire logic [1:0]                          rsp_digit_enables,
   output wire logic [4:0]                          rsp_device_id,
   output wire logic [6:0]                          rsp_display_number,
   input  wire logic                                csr_write_enable,
   input  wire logic [swid_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [swid_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   swid_pkg::cfg_type    cfg;
   swid_pkg::item_type   item_ff;
   swid_pkg::result_type result;

   logic in_valid_ff,  in_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic step;
   logic accept;

   // Handshake between request register and result slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.command     <= req_command;
         item_ff.switch_bits <= req_switch_bits;
         item_ff.system_time <= req_system_time;
      end
   end

   swid_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   swid_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_segment_bits   = result.segment_bits;
   assign rsp_digit_enables  = result.digit_enables;
   assign rsp_device_id      = result.device_id;
   assign rsp_display_number = result.display_number;

endmodule

`default_nettype wire

[src/swid_csr.sv]
// Configuration registers of the switch id segment display.
`default_nettype none

module swid_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_enable,
   input  wire logic [swid_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [swid_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output swid_pkg::cfg_type                          cfg
);

   swid_pkg::cfg_type cfg_ff;
   swid_pkg::cfg_type cfg_in;

   // Decode the index and replace the addressed register, masked to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            swid_pkg::CSR_MAJOR_VERSION: cfg_in.major_version = csr_write_data[3:0];
            swid_pkg::CSR_MINOR_VERSION: cfg_in.minor_version = csr_write_data[3:0];
            swid_pkg::CSR_STABLE_LIMIT:  cfg_in.stable_limit  = csr_write_data[15:0];
            swid_pkg::CSR_ID_WINDOW:     cfg_in.id_window     = csr_write_data[31:0];
            swid_pkg::CSR_MARK_WINDOW:   cfg_in.mark_window   = csr_write_data[31:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.major_version <= 4'd0;
         cfg_ff.minor_version <= 4'd0;
         cfg_ff.stable_limit  <= swid_pkg::STABLE_LIMIT_RESET;
         cfg_ff.id_window     <= swid_pkg::ID_WINDOW_RESET;
         cfg_ff.mark_window   <= swid_pkg::MARK_WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[src/swid_core.sv]
// Display and debounce state with its single-pass update for one word.
`default_nettype none

module swid_core #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire swid_pkg::item_type  item,
   input  wire swid_pkg::cfg_type   cfg,
   output swid_pkg::result_type     result
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                  blank_done_ff, blank_done_in;
   logic                  digit_sel_ff,  digit_sel_in;
   logic [6:0]            shown_ff,      shown_in;
   logic [6:0]            seg_ff,        seg_in;
   logic [1:0]            enable_ff,     enable_in;
   logic [4:0]            id_ff,         id_in;
   logic [3:0]            last_sw_ff,    last_sw_in;
   logic [COUNT_BITS-1:0] count_ff,      count_in;
   logic [31:0]           mark_ff,       mark_in;

   logic [3:0]            tens;
   logic [3:0]            ones;
   logic [3:0]            digit;
   logic [7:0]            version_raw;
   logic [6:0]            version_num;
   logic [COUNT_BITS-1:0] count_inc;
   logic [31:0]           diff;

   // Split the shown number into digits
   always_comb begin
      tens = swid_pkg::tens_of(shown_ff);
      ones = 4'(shown_ff - 7'(tens) * 7'd10);
      if (!digit_sel_ff) begin
         digit = (tens == 4'd0) ? swid_pkg::DIGIT_BLANK : tens;
      end else begin
         digit = ones;
      end
   end

   // Version number reduced below 100 with one compare and subtract
   always_comb begin
      version_raw = 8'(cfg.major_version) * 8'd10 + 8'(cfg.minor_version);
      version_num = (version_raw >= 8'd100) ? 7'(version_raw - 8'd100) : version_raw[6:0];
   end

   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);
   assign diff      = item.system_time - mark_ff;

   // Next state for a refresh tick or a switch sample
   always_comb begin
      blank_done_in = blank_done_ff;
      digit_sel_in  = digit_sel_ff;
      shown_in      = shown_ff;
      seg_in        = seg_ff;
      enable_in     = enable_ff;
      id_in         = id_ff;
      last_sw_in    = last_sw_ff;
      count_in      = count_ff;
      mark_in       = mark_ff;
      if (item.command == swid_pkg::CMD_REFRESH) begin
         if (!blank_done_ff) begin
            enable_in     = swid_pkg::ENABLE_NONE;
            blank_done_in = 1'b1;
         end else begin
            blank_done_in = 1'b0;
            digit_sel_in  = ~digit_sel_ff;
            seg_in        = swid_pkg::seg_decode(digit);
            enable_in     = digit_sel_ff ? swid_pkg::ENABLE_ONES : swid_pkg::ENABLE_TENS;
         end
      end else begin
         count_in = count_inc;
         if (item.switch_bits != last_sw_ff) begin
            count_in   = '0;
            last_sw_in = item.switch_bits;
         end else if (32'(count_inc) > 32'(cfg.stable_limit)) begin
            if (diff < cfg.id_window) begin
               id_in    = 5'(item.switch_bits) + 5'd1;
               shown_in = 7'(5'(item.switch_bits) + 5'd1);
               count_in = '0;
            end else begin
               shown_in = version_num;
               if (diff > cfg.mark_window) begin
                  mark_in = item.system_time;
               end
            end
         end
      end
   end

   // Advance state only when a word moves into the result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_done_ff <= 1'b0;
         digit_sel_ff  <= 1'b0;
         shown_ff      <= 7'd0;
         seg_ff        <= 7'd0;
         enable_ff     <= swid_pkg::ENABLE_NONE;
         id_ff         <= 5'd0;
         last_sw_ff    <= 4'd0;
         count_ff      <= '0;
         mark_ff       <= 32'd0;
      end else if (step) begin
         blank_done_ff <= blank_done_in;
         digit_sel_ff  <= digit_sel_in;
         shown_ff      <= shown_in;
         seg_ff        <= seg_in;
         enable_ff     <= enable_in;
         id_ff         <= id_in;
         last_sw_ff    <= last_sw_in;
         count_ff      <= count_in;
         mark_ff       <= mark_in;
      end
   end

   assign result.segment_bits   = seg_ff;
   assign result.digit_enables  = enable_ff;
   assign result.device_id      = id_ff;
   assign result.display_number = shown_ff;

endmodule

`default_nettype wire

[src/swid_checker.sv]
// Port-level checks of the switch id segment display and their bind to the top level.
`default_nettype none

module swid_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [6:0] rsp_segment_bits,
   input wire logic [1:0] rsp_digit_enables,
   input wire logic [4:0] rsp_device_id,
   input wire logic [6:0] rsp_display_number
);

   // No result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_bits)
         && $stable(rsp_digit_enables) && $stable(rsp_device_id)
         && $stable(rsp_display_number))
      else $error("stalled result changed");

   // At most one digit is driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_digit_enables != 2'b11)
      else $error("both digits enabled");

   // Shown number and device id stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_display_number < 7'd100 && rsp_device_id <= 5'd16)
      else $error("display number or device id out of range");

endmodule

bind switch_id_two_digit_segment_display swid_checker u_swid_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_segment_bits   (rsp_segment_bits),
   .rsp_digit_enables  (rsp_digit_enables),
   .rsp_device_id      (rsp_device_id),
   .rsp_display_number (rsp_display_number)
);

`default_nettype wire

[bench/tb_switch_id_two_digit_segment_display.sv]
// Self-checking testbench for the switch id two-digit segment display.
`timescale 1ns / 100ps

module tb_switch_id_two_digit_segment_display;

   localparam int COUNT_BITS  = 16;
   localparam int SETTLE      = 4;
   localparam int PHASES      = 8;
   localparam int PHASE_WORDS = 115;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   // Active-low glyphs, index 10 is the blank pattern
   localparam logic [10:0][6:0] GLYPH = {7'h7F, 7'h10, 7'h00, 7'h78, 7'h02, 7'h12,
                                         7'h19, 7'h30, 7'h24, 7'h79, 7'h40};

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic                                req_command;
   logic [3:0]                          req_switch_bits;
   logic [31:0]                         req_system_time;
   logic                                rsp_valid;
   logic                                rsp_stall;
   logic [6:0]                          rsp_segment_bits;
   logic [1:0]                          rsp_digit_enables;
   logic [4:0]                          rsp_device_id;
   logic [6:0]                          rsp_display_number;
   logic                                csr_write_enable;
   logic [swid_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [swid_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   switch_id_two_digit_segment_display #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_switch_bits    (req_switch_bits),
      .req_system_time    (req_system_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_segment_bits   (rsp_segment_bits),
      .rsp_digit_enables  (rsp_digit_enables),
      .rsp_device_id      (rsp_device_id),
      .rsp_display_number (rsp_display_number),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // Display and debounce state as the block should hold it
   swid_pkg::cfg_type     csr_copy;
   logic                  blank_done;
   logic                  tens_sel;
   logic [6:0]            num_shown;
   logic [6:0]            seg_level;
   logic [1:0]            enables;
   logic [4:0]            dev_id;
   logic [3:0]            prev_sw;
   logic [COUNT_BITS-1:0] steady_cnt;
   logic [31:0]           mark_time;

   swid_pkg::result_type pending_display[$];
   logic [31:0] tick_now;
   bit          sender_idling;
   bit          receiver_idling;
   int          hold_request;
   int          hold_left;
   int          burst_left;
   int unsigned err_count;
   int unsigned words_sent;
   int unsigned words_checked;
   int unsigned ids_taken;
   int unsigned csr_writes;
   int unsigned long_holds;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Advance the display on a refresh tick or debounce a switch sample, then queue the word
   task automatic compute_display_word(input logic cmd, input logic [3:0] sw,
                                       input logic [31:0] now);
      logic [3:0]  digit;
      logic [31:0] since;
      logic [7:0]  version;
      if (cmd == swid_pkg::CMD_REFRESH) begin
         if (!blank_done) begin
            enables    = swid_pkg::ENABLE_NONE;
            blank_done = 1'b1;
         end else begin
            blank_done = 1'b0;
            tens_sel   = ~tens_sel;
            num_shown  = num_shown % 7'd100;
            digit      = tens_sel ? 4'(num_shown / 7'd10) : 4'(num_shown % 7'd10);
            if (tens_sel && num_shown < 7'd10)
               digit = swid_pkg::DIGIT_BLANK;
            seg_level = GLYPH[digit];
            enables   = tens_sel ? swid_pkg::ENABLE_TENS : swid_pkg::ENABLE_ONES;
         end
      end else begin
         if (steady_cnt != '1)
            steady_cnt++;
         if (sw != prev_sw) begin
            steady_cnt = '0;
            prev_sw    = sw;
         end else if (32'(steady_cnt) > 32'(csr_copy.stable_limit)) begin
            since = now - mark_time;
            if (since < csr_copy.id_window) begin
               dev_id     = 5'(sw) + 5'd1;
               num_shown  = 7'(dev_id);
               steady_cnt = '0;
               ids_taken++;
            end else begin
               version   = 8'(10 * int'(csr_copy.major_version)
                              + int'(csr_copy.minor_version));
               num_shown = 7'(version % 8'd100);
               if (since > csr_copy.mark_window)
                  mark_time = now;
            end
         end
      end
      pending_display.push_back('{segment_bits: seg_level, digit_enables: enables,
                                  device_id: dev_id, display_number: num_shown});
   endtask

   // Offer one request word, with an occasional gap, and hold it until accepted
   task automatic send_word(input logic cmd, input logic [3:0] sw, input logic [31:0] t);
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_switch_bits <= sw;
      req_system_time <= t;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      compute_display_word(cmd, sw, t);
      words_sent++;
   endtask

   task automatic send_refresh();
      send_word(swid_pkg::CMD_REFRESH, 4'($urandom), $urandom);
   endtask

   // Step the system time, mostly forward by a few ticks, now and then a jump
   task automatic send_sample(input logic [3:0] sw);
      if ($urandom_range(0, 40) == 0)
         tick_now = $urandom;
      else
         tick_now = tick_now + 32'($urandom_range(0, 9));
      send_word(swid_pkg::CMD_SAMPLE, sw, tick_now);
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_display.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one register and mirror it, masked to its width
   task automatic write_reg(input logic [swid_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         swid_pkg::CSR_MAJOR_VERSION: csr_copy.major_version = data[3:0];
         swid_pkg::CSR_MINOR_VERSION: csr_copy.minor_version = data[3:0];
         swid_pkg::CSR_STABLE_LIMIT:  csr_copy.stable_limit  = data[15:0];
         swid_pkg::CSR_ID_WINDOW:     csr_copy.id_window     = data;
         swid_pkg::CSR_MARK_WINDOW:   csr_copy.mark_window   = data;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_window(input int span);
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return '1;
         default: return 32'($urandom_range(1, span));
      endcase
   endfunction

   // Reset values, leading zero blanking, id take-over, version with mark move,
   // time wrap, masked writes and writes to unused indexes
   task automatic test_directed();
      wait_drain();
      repeat (4) send_refresh();
      wait_drain();
      write_reg(swid_pkg::CSR_STABLE_LIMIT, 32'hABCD_0000);
      write_reg(swid_pkg::CSR_MAJOR_VERSION, 32'hFFFF_FFF3);
      write_reg(swid_pkg::CSR_MINOR_VERSION, 32'h0000_0017);
      for (int i = int'(swid_pkg::CSR_MARK_WINDOW) + 1;
           i < (1 << swid_pkg::CSR_INDEX_BITS); i++)
         write_reg(swid_pkg::CSR_INDEX_BITS'(i), $urandom);
      send_word(swid_pkg::CMD_SAMPLE, 4'hF, 32'd5);
      send_word(swid_pkg::CMD_SAMPLE, 4'hF, 32'd6);
      repeat (2) send_refresh();
      send_word(swid_pkg::CMD_SAMPLE, 4'hF, 32'hFFFF_FFFF);
      repeat (2) send_refresh();
      send_word(swid_pkg::CMD_SAMPLE, 4'hF, 32'd0);
      send_word(swid_pkg::CMD_SAMPLE, 4'h0, 32'd2);
      send_word(swid_pkg::CMD_SAMPLE, 4'h0, 32'd3);
      repeat (4) send_refresh();
      tick_now = 32'd3;
   endtask

   // Out-of-range version digits and the window extremes
   task automatic test_register_extremes();
      wait_drain();
      write_reg(swid_pkg::CSR_MAJOR_VERSION, 32'hF);
      write_reg(swid_pkg::CSR_MINOR_VERSION, 32'hF);
      write_reg(swid_pkg::CSR_ID_WINDOW, 32'd0);
      write_reg(swid_pkg::CSR_MARK_WINDOW, 32'hFFFF_FFFF);
      send_word(swid_pkg::CMD_SAMPLE, 4'h0, 32'h8000_0000);
      repeat (4) send_refresh();
      wait_drain();
      write_reg(swid_pkg::CSR_ID_WINDOW, 32'hFFFF_FFFF);
      write_reg(swid_pkg::CSR_MARK_WINDOW, 32'd0);
      send_word(swid_pkg::CMD_SAMPLE, 4'h0, 32'h8000_0001);
      send_word(swid_pkg::CMD_SAMPLE, 4'h0, 32'h8000_0002);
      repeat (2) send_refresh();
   endtask

   // Hold one switch value across a larger stable limit, then lower the limit
   // so the count left over clears it on the next sample
   task automatic test_long_hold();
      wait_drain();
      write_reg(swid_pkg::CSR_STABLE_LIMIT, 32'd60);
      write_reg(swid_pkg::CSR_ID_WINDOW, 32'hFFFF_FFFF);
      repeat (64) send_sample(4'h9);
      wait_drain();
      write_reg(swid_pkg::CSR_STABLE_LIMIT, 32'd1);
      send_word(swid_pkg::CMD_SAMPLE, 4'h9, mark_time + 32'd7);
      repeat (2) send_refresh();
   endtask

   // Stall the output for a long stretch while words keep coming, then pause the sender
   task automatic test_output_backpressure();
      wait_drain();
      sender_idling = 1'b0;
      hold_request  = 40;
      repeat (30) begin
         if ($urandom_range(0, 1) == 0)
            send_refresh();
         else
            send_sample(4'($urandom));
      end
      wait_drain();
      sender_idling = 1'b1;
   endtask

   // Random settings, then debounce runs of one value mixed with refresh ticks and noise
   task automatic test_random_phase(input int n_words);
      int         sent;
      int         run_len;
      logic [3:0] held;
      logic [3:0] major;
      logic [3:0] minor;
      logic [15:0] limit;
      wait_drain();
      major = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      minor = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
      case ($urandom_range(0, 3))
         0:       limit = 16'd0;
         3:       limit = 16'($urandom_range(10, 40));
         default: limit = 16'($urandom_range(1, 6));
      endcase
      write_reg(swid_pkg::CSR_MAJOR_VERSION, {28'($urandom), major});
      write_reg(swid_pkg::CSR_MINOR_VERSION, {28'($urandom), minor});
      write_reg(swid_pkg::CSR_STABLE_LIMIT, {16'($urandom), limit});
      write_reg(swid_pkg::CSR_ID_WINDOW, pick_window(60));
      write_reg(swid_pkg::CSR_MARK_WINDOW, pick_window(150));
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(0, 19) == 0) begin
            send_sample(4'($urandom));
            sent++;
         end else begin
            held    = 4'($urandom);
            run_len = $urandom_range(1, int'(limit) + 6);
            repeat (run_len) begin
               while ($urandom_range(0, 2) == 0) begin
                  send_refresh();
                  sent++;
               end
               send_sample(held);
               sent++;
            end
         end
      end
   endtask

   // Compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      swid_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_display.size() == 0) begin
            $display("%0t: unexpected result word seg %h en %h id %0d num %0d", $time,
                     rsp_segment_bits, rsp_digit_enables, rsp_device_id,
                     rsp_display_number);
            err_count++;
         end else begin
            want = pending_display.pop_front();
            words_checked++;
            if (rsp_segment_bits !== want.segment_bits) begin
               $display("%0t: segment_bits expected %h actual %h", $time,
                        want.segment_bits, rsp_segment_bits);
               err_count++;
            end
            if (rsp_digit_enables !== want.digit_enables) begin
               $display("%0t: digit_enables expected %h actual %h", $time,
                        want.digit_enables, rsp_digit_enables);
               err_count++;
            end
            if (rsp_device_id !== want.device_id) begin
               $display("%0t: device_id expected %0d actual %0d", $time,
                        want.device_id, rsp_device_id);
               err_count++;
            end
            if (rsp_display_number !== want.display_number) begin
               $display("%0t: display_number expected %0d actual %0d", $time,
                        want.display_number, rsp_display_number);
               err_count++;
            end
         end
      end
   end

   // Output stall: long hold on request, otherwise short random bursts
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
         long_holds++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= swid_pkg::CMD_REFRESH;
      req_switch_bits  <= '0;
      req_system_time  <= '0;
      rsp_stall        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= swid_pkg::CSR_MAJOR_VERSION;
      csr_write_data   <= '0;
      csr_copy   = '{major_version: 4'd0, minor_version: 4'd0,
                     stable_limit: swid_pkg::STABLE_LIMIT_RESET,
                     id_window: swid_pkg::ID_WINDOW_RESET,
                     mark_window: swid_pkg::MARK_WINDOW_RESET};
      blank_done = 1'b0;
      tens_sel   = 1'b0;
      num_shown  = '0;
      seg_level  = '0;
      enables    = swid_pkg::ENABLE_NONE;
      dev_id     = '0;
      prev_sw    = '0;
      steady_cnt = '0;
      mark_time  = '0;
      tick_now   = '0;
      sender_idling   = 1'b1;
      receiver_idling = 1'b1;
      hold_request = 0;
      hold_left    = 0;
      burst_left   = 0;
      err_count     = 0;
      words_sent    = 0;
      words_checked = 0;
      ids_taken     = 0;
      csr_writes    = 0;
      long_holds    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_extremes();
      test_long_hold();
      test_output_backpressure();
      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1) begin
            sender_idling   = 1'b0;
            receiver_idling = 1'b0;
         end
         test_random_phase(PHASE_WORDS);
      end
      wait_drain();

      $display("Covered %0d request words and %0d checked result words over %0d csr writes,",
               words_sent, words_checked, csr_writes);
      $display("with %0d device id take-overs, a long debounce hold and %0d long stalls.",
               ids_taken, long_holds);
      if (err_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
